// ===== rtl/core/pirb_pkg.sv =====
package pirb_pkg;

  localparam int COORD_BITS_DEF   = 24;
  localparam int FRAC_BITS_DEF    = 8;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ANGLE_BITS = 18;
  localparam int GUARD_BITS = 16;
  // CORDIC angle accumulator: degrees, ZFRAC fraction bits
  localparam int ZFRAC      = 24;
  localparam int ZW         = 34;
  // extra bits of the CORDIC datapath over the coordinate width
  localparam int CW_EXTRA   = GUARD_BITS + 3;

  // inverse CORDIC gain, KSHIFT fraction bits
  localparam int KW     = 31;
  localparam int KSHIFT = 30;
  localparam logic [KW-1:0] KGAIN = 31'd652032874;

  localparam int TABLE_LEN = 24;
  localparam logic [30:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
    31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938,
    31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
    31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
    31'd234684,    31'd117342,    31'd58671,     31'd29335,
    31'd14668,     31'd7334,      31'd3667,      31'd1833,
    31'd917,       31'd458,       31'd229,       31'd115
  };

endpackage

// ===== rtl/core/point_in_rotated_box_test.sv =====
// Point in rotated box: one query accepted per cycle, one hit bit out per query.
// Pipeline: two preparation stages, the gain multiply, one stage per CORDIC micro-rotation
// and the compare/output register.
// The whole pipeline holds while a result waits under out_stall_i; otherwise full rate.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data is not reset.
module point_in_rotated_box_test #(
  parameter int COORD_BITS   = pirb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS    = pirb_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = pirb_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [COORD_BITS-1:0]           center_x_i,
  input  logic signed [COORD_BITS-1:0]           center_y_i,
  input  logic        [COORD_BITS-2:0]           box_width_i,
  input  logic        [COORD_BITS-2:0]           box_height_i,
  input  logic signed [pirb_pkg::ANGLE_BITS-1:0] angle_deg_i,
  input  logic signed [COORD_BITS-1:0]           point_x_i,
  input  logic signed [COORD_BITS-1:0]           point_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   hit_o
);

  localparam int CW = COORD_BITS + pirb_pkg::CW_EXTRA;
  localparam int ZW = pirb_pkg::ZW;

  logic adv;

  // pipeline moves whenever the output register is empty or its transfer completes
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  logic                       p_valid;
  logic signed [COORD_BITS:0] p_x, p_y;
  logic signed [ZW-1:0]       p_z;
  logic [COORD_BITS-2:0]      p_w, p_h;

  pirb_prep #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (in_valid_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .angle_deg_i  (angle_deg_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .valid_o      (p_valid),
    .x_o          (p_x),
    .y_o          (p_y),
    .z_o          (p_z),
    .width_o      (p_w),
    .height_o     (p_h)
  );

  logic                  c_valid [CORDIC_STEPS+1];
  logic signed [CW-1:0]  c_x     [CORDIC_STEPS+1];
  logic signed [CW-1:0]  c_y     [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  c_z     [CORDIC_STEPS+1];
  logic [COORD_BITS-2:0] c_w     [CORDIC_STEPS+1];
  logic [COORD_BITS-2:0] c_h     [CORDIC_STEPS+1];

  pirb_gain #(
    .COORD_BITS (COORD_BITS)
  ) u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (p_valid),
    .x_i      (p_x),
    .y_i      (p_y),
    .z_i      (p_z),
    .width_i  (p_w),
    .height_i (p_h),
    .valid_o  (c_valid[0]),
    .x_o      (c_x[0]),
    .y_o      (c_y[0]),
    .z_o      (c_z[0]),
    .width_o  (c_w[0]),
    .height_o (c_h[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    pirb_cordic_stage #(
      .COORD_BITS (COORD_BITS),
      .IDX        (i)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .valid_i  (c_valid[i]),
      .x_i      (c_x[i]),
      .y_i      (c_y[i]),
      .z_i      (c_z[i]),
      .width_i  (c_w[i]),
      .height_i (c_h[i]),
      .valid_o  (c_valid[i+1]),
      .x_o      (c_x[i+1]),
      .y_o      (c_y[i+1]),
      .z_o      (c_z[i+1]),
      .width_o  (c_w[i+1]),
      .height_o (c_h[i+1])
    );
  end

  pirb_test #(
    .COORD_BITS (COORD_BITS)
  ) u_test (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (c_valid[CORDIC_STEPS]),
    .x_i      (c_x[CORDIC_STEPS]),
    .y_i      (c_y[CORDIC_STEPS]),
    .width_i  (c_w[CORDIC_STEPS]),
    .height_i (c_h[CORDIC_STEPS]),
    .valid_o  (out_valid_o),
    .hit_o    (hit_o)
  );

endmodule

// ===== rtl/core/pirb_prep.sv =====
module pirb_prep #(
  parameter int COORD_BITS = pirb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pirb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [COORD_BITS-1:0]      center_x_i,
  input  logic signed [COORD_BITS-1:0]      center_y_i,
  input  logic        [COORD_BITS-2:0]      box_width_i,
  input  logic        [COORD_BITS-2:0]      box_height_i,
  input  logic signed [pirb_pkg::ANGLE_BITS-1:0] angle_deg_i,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  output logic                              valid_o,
  output logic signed [COORD_BITS:0]        x_o,
  output logic signed [COORD_BITS:0]        y_o,
  output logic signed [pirb_pkg::ZW-1:0]    z_o,
  output logic        [COORD_BITS-2:0]      width_o,
  output logic        [COORD_BITS-2:0]      height_o
);

  localparam int AW      = pirb_pkg::ANGLE_BITS;
  localparam int ZW      = pirb_pkg::ZW;
  localparam int XW      = COORD_BITS + 1;
  localparam int FULL    = 360 * (2 ** FRAC_BITS);
  localparam int HALF    = FULL / 2;
  localparam int QUARTER = FULL / 4;
  localparam int AMAG    = 2 ** (AW - 1);
  // multiple of a full turn that lifts any negated angle above zero
  localparam int OFFSET  = FULL * ((AMAG + FULL - 1) / FULL);
  localparam int UMAX    = AMAG + OFFSET;
  localparam int QB      = $clog2(UMAX / FULL + 1);
  localparam int UW      = $clog2(UMAX + 1);
  localparam int TW      = $clog2(FULL) + 1;
  localparam int ZSH     = pirb_pkg::ZFRAC - FRAC_BITS;

  // stage A: offsets and angle reduced into (-180, 180]
  logic signed [AW:0]     neg_ang;
  logic signed [UW:0]     lifted;
  logic        [UW-1:0]   red;
  logic        [UW-1:0]   sub_step;
  logic signed [TW-1:0]   red_s;
  logic signed [TW-1:0]   ta_d;
  logic signed [XW-1:0]   dxa_d, dya_d;

  logic                   va_q;
  logic signed [TW-1:0]   ta_q;
  logic signed [XW-1:0]   dxa_q, dya_q;
  logic [COORD_BITS-2:0]  wa_q, ha_q;

  always_comb begin
    neg_ang = -(AW + 1)'(angle_deg_i);
    lifted  = (UW + 1)'(neg_ang) + (UW + 1)'(OFFSET);
    red     = lifted[UW-1:0];
    sub_step = '0;
    // restoring reduction by a constant, one compare-subtract per quotient bit
    for (int k = QB - 1; k >= 0; k--) begin
      sub_step = UW'(FULL) << k;
      if (red >= sub_step) begin
        red = red - sub_step;
      end
    end
    red_s = $signed(TW'(red));
    if (red > UW'(HALF)) begin
      ta_d = red_s - TW'(FULL);
    end else begin
      ta_d = red_s;
    end
    dxa_d = XW'(point_x_i) - XW'(center_x_i);
    dya_d = XW'(point_y_i) - XW'(center_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q  <= ta_d;
      dxa_q <= dxa_d;
      dya_q <= dya_d;
      wa_q  <= box_width_i;
      ha_q  <= box_height_i;
    end
  end

  // stage B: fold into +-90 degrees by a half turn of the offset
  logic signed [TW-1:0]   tb_d;
  logic signed [XW-1:0]   xb_d, yb_d;
  logic signed [ZW-1:0]   zb_d;

  logic                   vb_q;
  logic signed [XW-1:0]   xb_q, yb_q;
  logic signed [ZW-1:0]   zb_q;
  logic [COORD_BITS-2:0]  wb_q, hb_q;

  always_comb begin
    tb_d = ta_q;
    xb_d = dxa_q;
    yb_d = dya_q;
    if (ta_q > TW'(QUARTER)) begin
      tb_d = ta_q - TW'(HALF);
      xb_d = -dxa_q;
      yb_d = -dya_q;
    end else if (ta_q < -TW'(QUARTER)) begin
      tb_d = ta_q + TW'(HALF);
      xb_d = -dxa_q;
      yb_d = -dya_q;
    end
    zb_d = ZW'(tb_d) <<< ZSH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xb_q <= xb_d;
      yb_q <= yb_d;
      zb_q <= zb_d;
      wb_q <= wa_q;
      hb_q <= ha_q;
    end
  end

  assign valid_o  = vb_q;
  assign x_o      = xb_q;
  assign y_o      = yb_q;
  assign z_o      = zb_q;
  assign width_o  = wb_q;
  assign height_o = hb_q;

endmodule

// ===== rtl/core/pirb_gain.sv =====
module pirb_gain #(
  parameter int COORD_BITS = pirb_pkg::COORD_BITS_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic signed [COORD_BITS:0]                        x_i,
  input  logic signed [COORD_BITS:0]                        y_i,
  input  logic signed [pirb_pkg::ZW-1:0]                    z_i,
  input  logic        [COORD_BITS-2:0]                      width_i,
  input  logic        [COORD_BITS-2:0]                      height_i,
  output logic                                              valid_o,
  output logic signed [COORD_BITS+pirb_pkg::CW_EXTRA-1:0]   x_o,
  output logic signed [COORD_BITS+pirb_pkg::CW_EXTRA-1:0]   y_o,
  output logic signed [pirb_pkg::ZW-1:0]                    z_o,
  output logic        [COORD_BITS-2:0]                      width_o,
  output logic        [COORD_BITS-2:0]                      height_o
);

  localparam int CW  = COORD_BITS + pirb_pkg::CW_EXTRA;
  localparam int PW  = COORD_BITS + 1 + pirb_pkg::KW;
  localparam int SH  = pirb_pkg::KSHIFT - pirb_pkg::GUARD_BITS;
  localparam int RND = 2 ** (SH - 1);

  logic signed [PW-1:0] kgain;
  logic signed [PW-1:0] prod_x, prod_y;
  logic signed [PW-1:0] shx, shy;

  // round half up into the guard bits
  always_comb begin
    kgain  = PW'(pirb_pkg::KGAIN);
    prod_x = PW'(x_i) * kgain + PW'(RND);
    prod_y = PW'(y_i) * kgain + PW'(RND);
    shx    = prod_x >>> SH;
    shy    = prod_y >>> SH;
  end

  logic                  v_q;
  logic signed [CW-1:0]  x_q, y_q;
  logic signed [pirb_pkg::ZW-1:0] z_q;
  logic [COORD_BITS-2:0] w_q, h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= shx[CW-1:0];
      y_q <= shy[CW-1:0];
      z_q <= z_i;
      w_q <= width_i;
      h_q <= height_i;
    end
  end

  assign valid_o  = v_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign z_o      = z_q;
  assign width_o  = w_q;
  assign height_o = h_q;

endmodule

// ===== rtl/core/pirb_cordic_stage.sv =====
module pirb_cordic_stage #(
  parameter int COORD_BITS = pirb_pkg::COORD_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic signed [COORD_BITS+pirb_pkg::CW_EXTRA-1:0]   x_i,
  input  logic signed [COORD_BITS+pirb_pkg::CW_EXTRA-1:0]   y_i,
  input  logic signed [pirb_pkg::ZW-1:0]                    z_i,
  input  logic        [COORD_BITS-2:0]                      width_i,
  input  logic        [COORD_BITS-2:0]                      height_i,
  output logic                                              valid_o,
  output logic signed [COORD_BITS+pirb_pkg::CW_EXTRA-1:0]   x_o,
  output logic signed [COORD_BITS+pirb_pkg::CW_EXTRA-1:0]   y_o,
  output logic signed [pirb_pkg::ZW-1:0]                    z_o,
  output logic        [COORD_BITS-2:0]                      width_o,
  output logic        [COORD_BITS-2:0]                      height_o
);

  localparam int CW = COORD_BITS + pirb_pkg::CW_EXTRA;
  localparam int ZW = pirb_pkg::ZW;

  logic signed [CW-1:0] xs, ys, x_d, y_d;
  logic signed [ZW-1:0] atn, z_d;

  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    atn = ZW'(pirb_pkg::ATAN_DEG_Q24[IDX]);
    if (!z_i[ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atn;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atn;
    end
  end

  logic                  v_q;
  logic signed [CW-1:0]  x_q, y_q;
  logic signed [ZW-1:0]  z_q;
  logic [COORD_BITS-2:0] w_q, h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      w_q <= width_i;
      h_q <= height_i;
    end
  end

  assign valid_o  = v_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign z_o      = z_q;
  assign width_o  = w_q;
  assign height_o = h_q;

endmodule

// ===== rtl/core/pirb_test.sv =====
module pirb_test #(
  parameter int COORD_BITS = pirb_pkg::COORD_BITS_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic signed [COORD_BITS+pirb_pkg::CW_EXTRA-1:0]   x_i,
  input  logic signed [COORD_BITS+pirb_pkg::CW_EXTRA-1:0]   y_i,
  input  logic        [COORD_BITS-2:0]                      width_i,
  input  logic        [COORD_BITS-2:0]                      height_i,
  output logic                                              valid_o,
  output logic                                              hit_o
);

  localparam int CW = COORD_BITS + pirb_pkg::CW_EXTRA;
  localparam int GB = pirb_pkg::GUARD_BITS;

  // compare twice the rotated offset against the full size, both in guard units
  logic signed [CW:0] twice_x, twice_y, lim_x, lim_y;
  logic               hit_d;

  always_comb begin
    twice_x = {x_i, 1'b0};
    twice_y = {y_i, 1'b0};
    lim_x   = (CW + 1)'({width_i, {GB{1'b0}}});
    lim_y   = (CW + 1)'({height_i, {GB{1'b0}}});
    hit_d   = (twice_x < lim_x) && (twice_x > -lim_x) &&
              (twice_y < lim_y) && (twice_y > -lim_y);
  end

  logic v_q, hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = v_q;
  assign hit_o   = hit_q;

endmodule

// ===== dv/pirb_hit_sb_pkg.sv =====
`timescale 1ns / 1ps

package pirb_hit_sb_pkg;

  localparam int    COORD_FRAC   = 8;
  localparam int    GAIN_GUARD   = 16;
  localparam int    ZETA_FRAC    = 24;
  localparam int    ROT_STEPS    = 16;
  localparam longint INV_GAIN    = 64'sd652032874;
  localparam int    INV_GAIN_SH  = 30;
  localparam longint TURN        = 360 * (1 << COORD_FRAC);

  // arctan(2^-i) in degrees, 24 fraction bits, rounded to nearest
  localparam longint ROT_STEP_DEG_Q24 [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  class hit_scoreboard;
    bit          expected_hits[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    // strict test on 2*r against size scaled to the guard bits
    function bit within_half(longint r, longint size);
      longint twice;
      longint lim;
      twice = r * 2;
      lim   = size * (64'sd1 <<< GAIN_GUARD);
      return (twice < lim) && (twice > -lim);
    endfunction

    function bit predict_hit(longint cx, longint cy, longint w, longint h,
                             longint ang, longint px, longint py);
      longint t;
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      longint rnd;
      t = (-ang) % TURN;
      if (t < 0) t += TURN;
      if (t > TURN / 2) t -= TURN;
      x = px - cx;
      y = py - cy;
      // beyond a quarter turn: flip by half a turn first
      if (t > TURN / 4) begin
        t -= TURN / 2;
        x = -x;
        y = -y;
      end else if (t < -(TURN / 4)) begin
        t += TURN / 2;
        x = -x;
        y = -y;
      end
      rnd = 64'sd1 <<< (INV_GAIN_SH - GAIN_GUARD - 1);
      x = (x * INV_GAIN + rnd) >>> (INV_GAIN_SH - GAIN_GUARD);
      y = (y * INV_GAIN + rnd) >>> (INV_GAIN_SH - GAIN_GUARD);
      z = t * (64'sd1 <<< (ZETA_FRAC - COORD_FRAC));
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z -= ROT_STEP_DEG_Q24[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z += ROT_STEP_DEG_Q24[i];
        end
      end
      return within_half(x, w) && within_half(y, h);
    endfunction

    function void note_query(longint cx, longint cy, longint w, longint h,
                             longint ang, longint px, longint py);
      expected_hits.push_back(predict_hit(cx, cy, w, h, ang, px, py));
    endfunction

    function void check_hit(logic hit);
      bit exp_hit;
      if (expected_hits.size() == 0) begin
        $error("hit: no query pending, expected none, actual %0b", hit);
        failures++;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (hit !== exp_hit) begin
          $error("hit: expected %0b, actual %0b", exp_hit, hit);
          failures++;
        end
      end
    endfunction
  endclass

endpackage

// ===== dv/tb_point_in_rotated_box_test.sv =====
`timescale 1ns / 1ps

module tb_point_in_rotated_box_test;

  localparam int CW              = pirb_pkg::COORD_BITS_DEF;
  localparam int AW              = pirb_pkg::ANGLE_BITS;
  localparam int LATENCY         = pirb_pkg::CORDIC_STEPS_DEF + 4;
  localparam int HOLD_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int ITEMS_PER_PHASE = 367;
  localparam int NUM_PHASES      = 3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic        [CW-2:0] box_width;
  logic        [CW-2:0] box_height;
  logic signed [AW-1:0] angle_deg;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic                 out_valid;
  logic                 out_stall;
  logic                 hit;

  int sender_idle_pct;
  int receiver_idle_pct;
  bit hold_req;
  int idle_cycles;

  pirb_hit_sb_pkg::hit_scoreboard sb = new();

  point_in_rotated_box_test dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .box_width_i (box_width),
    .box_height_i(box_height),
    .angle_deg_i (angle_deg),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .hit_o       (hit)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_query(longint'(center_x), longint'(center_y), longint'(box_width),
                      longint'(box_height), longint'(angle_deg),
                      longint'(point_x), longint'(point_y));
      end
      if (out_valid && !out_stall) sb.check_hit(hit);
    end
  end

  // receiver: random stall, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic longint rand_coord();
    return longint'($urandom_range(0, (1 << CW) - 1)) - (64'sd1 <<< (CW - 1));
  endfunction

  function automatic longint rand_size();
    if ($urandom_range(19) == 0) return 0;
    return longint'($urandom_range(0, (1 << $urandom_range(1, CW - 1)) - 1));
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > (64'sd1 <<< (CW - 1)) - 1) return (64'sd1 <<< (CW - 1)) - 1;
    if (v < -(64'sd1 <<< (CW - 1))) return -(64'sd1 <<< (CW - 1));
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic drive_query(longint cx, longint cy, longint w, longint h,
                             longint ang, longint px, longint py);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    center_x   <= cx[CW-1:0];
    center_y   <= cy[CW-1:0];
    box_width  <= w[CW-2:0];
    box_height <= h[CW-2:0];
    angle_deg  <= ang[AW-1:0];
    point_x    <= px[CW-1:0];
    point_y    <= py[CW-1:0];
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic random_query();
    longint cx;
    longint cy;
    longint w;
    longint h;
    longint ang;
    longint px;
    longint py;
    longint span;
    int     kind;
    kind = $urandom_range(99);
    w = rand_size();
    h = rand_size();
    if ($urandom_range(9) == 0) ang = longint'($urandom_range(0, (1 << AW) - 1)) - 131072;
    else ang = longint'($urandom_range(0, 2 * 92160)) - 92160;
    cx = rand_coord();
    cy = rand_coord();
    if (kind < 25) begin
      px = rand_coord();
      py = rand_coord();
    end else begin
      // point scattered around the box so that hits and near misses both occur
      span = ((w > h) ? w : h) * 3 / 4 + 1;
      px = clamp_coord(cx + longint'($urandom_range(0, 32'(2 * span))) - span);
      py = clamp_coord(cy + longint'($urandom_range(0, 32'(2 * span))) - span);
    end
    drive_query(cx, cy, w, h, ang, px, py);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    center_x          = '0;
    center_y          = '0;
    box_width         = '0;
    box_height        = '0;
    angle_deg         = '0;
    point_x           = '0;
    point_y           = '0;
    hold_req          = 1'b0;
    sender_idle_pct   = 38;
    receiver_idle_pct = 78;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: centre, empty boxes, edges, quarter turns, wrap, extremes
    drive_query(0, 0, 512, 512, 0, 0, 0);
    drive_query(0, 0, 0, 512, 0, 0, 0);
    drive_query(0, 0, 512, 0, 0, 0, 0);
    drive_query(0, 0, 512, 256, 0, 256, 0);
    drive_query(0, 0, 512, 256, 0, 0, 128);
    drive_query(1000, -2000, 2560, 768, 23040, 1000, -1700);
    drive_query(0, 0, 2560, 768, 46080, 900, 100);
    drive_query(0, 0, 2560, 768, -46080, -900, -100);
    drive_query(0, 0, 2560, 768, 69120, 100, 900);
    drive_query(0, 0, 2560, 768, -69120, -100, 900);
    drive_query(0, 0, 2560, 768, 92160, 1000, 0);
    drive_query(0, 0, 2560, 768, -92160, -1000, 0);
    drive_query(0, 0, 2560, 768, 23296, 50, 1000);
    drive_query(0, 0, 2560, 768, -23296, -50, 1000);
    drive_query(0, 0, 2560, 768, 131071, 1000, 50);
    drive_query(0, 0, 2560, 768, -131072, 1000, 50);
    drive_query(-8388608, -8388608, 8388607, 8388607, 0, 8388607, 8388607);
    drive_query(8388607, 8388607, 8388607, 8388607, 11520, -8388608, -8388608);
    drive_query(0, 0, 8388607, 8388607, 0, 4194000, 4194000);
    drive_query(0, 0, 8388607, 8388607, 11520, 0, 5931000);
    drive_query(-8388608, 8388607, 1, 1, 0, -8388608, 8388607);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 38;
          receiver_idle_pct = 78;
        end
        1: begin
          sender_idle_pct   = 78;
          receiver_idle_pct = 38;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          // long receiver hold-off while the sender keeps offering
          hold_req = 1'b1;
        end
      endcase
      repeat (ITEMS_PER_PHASE) random_query();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("hit: %0d results never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pirb_pkg.sv
rtl/core/pirb_prep.sv
rtl/core/pirb_gain.sv
rtl/core/pirb_cordic_stage.sv
rtl/core/pirb_test.sv
rtl/core/point_in_rotated_box_test.sv
dv/pirb_hit_sb_pkg.sv
dv/tb_point_in_rotated_box_test.sv
